[hw/rtl/lphm_pkg.sv]
// shared types and constants for the label pair hash map
package lphm_pkg;

    localparam int MOD_FIRST_DEF  = 127;
    localparam int MOD_SECOND_DEF = 113;
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int LABEL_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_SEARCH = 2'd0,
        ACT_ENTER  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HEAD,
        ST_HEAD_WAIT,
        ST_NODE,
        ST_NODE_WAIT,
        ST_CLEAR,
        ST_DONE
    } back_state_t;

endpackage

[hw/rtl/lphm_ram.sv]
// generic single write port ram with registered read
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lphm_front.sv]
// front end: accepts items, computes the bucket index one key byte at a time, fills the queue
module lphm_front
    import lphm_pkg::*;
#(
    parameter int MOD_FIRST  = MOD_FIRST_DEF,
    parameter int MOD_SECOND = MOD_SECOND_DEF,
    parameter int LABEL_BITS = LABEL_BITS_DEF,
    localparam int KEY_BITS  = 2 * LABEL_BITS,
    localparam int BKT_COUNT = MOD_FIRST + MOD_SECOND,
    localparam int BKT_BITS  = $clog2(BKT_COUNT),
    localparam int QW        = 2 + 2 * LABEL_BITS + 32 + BKT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_action,
    input  logic [LABEL_BITS-1:0] in_a,
    input  logic [LABEL_BITS-1:0] in_b,
    input  logic [31:0]           in_val,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [QW-1:0]         q_data
);

    localparam int DIG      = 8;
    localparam int STEPS    = (KEY_BITS + DIG - 1) / DIG;
    localparam int KEY_PAD  = STEPS * DIG;
    localparam int CNT_BITS = $clog2(STEPS + 1);
    localparam int R1_BITS  = $clog2(MOD_FIRST);
    localparam int R2_BITS  = $clog2(MOD_SECOND);
    localparam int X1_BITS  = R1_BITS + DIG;
    localparam int X2_BITS  = R2_BITS + DIG;
    localparam int P1_BITS  = X1_BITS + DIG;
    localparam int P2_BITS  = X2_BITS + DIG;
    localparam int RCP1     = (1 << X1_BITS) / MOD_FIRST;
    localparam int RCP2     = (1 << X2_BITS) / MOD_SECOND;

    // remainder one key byte at a time: reciprocal quotient estimate, then correction
    logic                  busy_reg, busy_next;
    logic                  phase_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [KEY_PAD-1:0]    key_reg;
    logic [R1_BITS-1:0]    r1_reg, r1_next;
    logic [R2_BITS-1:0]    r2_reg, r2_next;
    logic [DIG-1:0]        q1_reg, q1_next;
    logic [DIG-1:0]        q2_reg, q2_next;
    logic [X1_BITS-1:0]    x1, t1;
    logic [X2_BITS-1:0]    x2, t2;
    logic [P1_BITS-1:0]    p1;
    logic [P2_BITS-1:0]    p2;
    logic [1:0]            act_reg;
    logic [LABEL_BITS-1:0] a_reg, b_reg;
    logic [31:0]           val_reg;
    logic [BKT_BITS:0]     bsum;
    logic [BKT_BITS-1:0]   bkt;

    // two entry queue
    logic [QW-1:0] fifo_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    fill_reg;
    logic          push, pop;

    assign in_ready = !busy_reg;

    always_comb
    begin
        x1 = {r1_reg, key_reg[KEY_PAD-1 -: DIG]};
        x2 = {r2_reg, key_reg[KEY_PAD-1 -: DIG]};
        p1 = P1_BITS'(x1) * P1_BITS'(RCP1);
        p2 = P2_BITS'(x2) * P2_BITS'(RCP2);
        q1_next = p1[X1_BITS +: DIG];
        q2_next = p2[X2_BITS +: DIG];
        t1 = x1 - X1_BITS'(q1_reg) * X1_BITS'(MOD_FIRST);
        t2 = x2 - X2_BITS'(q2_reg) * X2_BITS'(MOD_SECOND);
        r1_next = (t1 >= X1_BITS'(MOD_FIRST)) ? R1_BITS'(t1 - X1_BITS'(MOD_FIRST))
                                              : R1_BITS'(t1);
        r2_next = (t2 >= X2_BITS'(MOD_SECOND)) ? R2_BITS'(t2 - X2_BITS'(MOD_SECOND))
                                               : R2_BITS'(t2);
        bsum = (BKT_BITS+1)'(r1_reg) + (BKT_BITS+1)'(r2_reg);
        bkt = (bsum >= (BKT_BITS+1)'(BKT_COUNT)) ? '0 : bsum[BKT_BITS-1:0];
        busy_next = busy_reg;
        push = 1'b0;
        if (!busy_reg)
        begin
            busy_next = in_valid;
        end
        else if (cnt_reg == CNT_BITS'(STEPS))
        begin
            push = fill_reg != 2'd2;
            busy_next = !push;
        end
    end

    assign pop = q_valid && q_ready;
    assign q_valid = fill_reg != 2'd0;
    assign q_data = fifo_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg)
        begin
            key_reg   <= KEY_PAD'({in_a, in_b});
            r1_reg    <= '0;
            r2_reg    <= '0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            act_reg   <= in_action;
            a_reg     <= in_a;
            b_reg     <= in_b;
            val_reg   <= in_val;
        end
        else if (cnt_reg != CNT_BITS'(STEPS))
        begin
            if (!phase_reg)
            begin
                q1_reg <= q1_next;
                q2_reg <= q2_next;
            end
            else
            begin
                r1_reg  <= r1_next;
                r2_reg  <= r2_next;
                key_reg <= key_reg << DIG;
                cnt_reg <= cnt_reg + 1'b1;
            end
            phase_reg <= !phase_reg;
        end
        if (push)
        begin
            fifo_reg[wp_reg] <= {bkt, val_reg, b_reg, a_reg, act_reg};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'd2)
        else $error("queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> fill_reg != 2'd2)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg != CNT_BITS'(STEPS) |=> busy_reg)
        else $error("division dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_data))
        else $error("queue head changed while waiting");

endmodule

[hw/rtl/lphm_back.sv]
// back end: walks bucket chains, links new nodes, clears the bucket table
module lphm_back
    import lphm_pkg::*;
#(
    parameter int MOD_FIRST  = MOD_FIRST_DEF,
    parameter int MOD_SECOND = MOD_SECOND_DEF,
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int LABEL_BITS = LABEL_BITS_DEF,
    localparam int BKT_COUNT = MOD_FIRST + MOD_SECOND,
    localparam int BKT_BITS  = $clog2(BKT_COUNT),
    localparam int QW        = 2 + 2 * LABEL_BITS + 32 + BKT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [QW-1:0] q_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [33:0]   out_data
);

    localparam int NB = $clog2(POOL_DEPTH);
    localparam int LB = $clog2(POOL_DEPTH + 1);
    localparam int NW = 2 * LABEL_BITS + 32 + LB;

    back_state_t state_reg, state_next;
    logic [1:0]            act_reg;
    logic [LABEL_BITS-1:0] a_reg, b_reg;
    logic [31:0]           val_reg;
    logic [BKT_BITS-1:0]   bkt_reg, clr_reg;
    logic [LB-1:0]         used_reg, link_reg, cnt_reg;
    logic                  ov_reg;
    logic                  found_reg;
    logic [33:0]           od_reg;

    logic                  hwe, nwe;
    logic [BKT_BITS-1:0]   hwaddr;
    logic [LB-1:0]         hwdata, hrdata;
    logic [NW-1:0]         nwdata, nrdata;
    logic [NB-1:0]         nraddr;
    logic [LABEL_BITS-1:0] na, nb;
    logic [31:0]           ne;
    logic [LB-1:0]         nn;
    logic                  load, hit, res_ld;
    logic [33:0]           res;

    assign {nn, ne, nb, na} = nrdata;
    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign load = q_valid && q_ready;
    assign hit = na == a_reg && nb == b_reg;
    assign nraddr = NB'(link_reg - 1'b1);

    lphm_ram #(.WIDTH(LB), .DEPTH(BKT_COUNT)) u_heads (
        .clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata),
        .raddr(bkt_reg), .rdata(hrdata)
    );

    lphm_ram #(.WIDTH(NW), .DEPTH(POOL_DEPTH)) u_nodes (
        .clk(clk), .we(nwe), .waddr(used_reg[NB-1:0]), .wdata(nwdata),
        .raddr(nraddr), .rdata(nrdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (clr_reg == BKT_BITS'(BKT_COUNT - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:      if (load) state_next = ST_HEAD;
            ST_HEAD:
            begin
                if (act_reg == ACT_CLEAR) state_next = ST_CLEAR;
                else if (act_reg == ACT_SEARCH) state_next = ST_HEAD_WAIT;
                else state_next = ST_DONE;
            end
            ST_HEAD_WAIT: state_next = ST_NODE;
            ST_NODE:      state_next = ST_NODE_WAIT;
            ST_NODE_WAIT:
            begin
                if (link_reg == '0 || hit || cnt_reg == LB'(POOL_DEPTH)) state_next = ST_DONE;
                else state_next = ST_NODE;
            end
            ST_CLEAR:
            begin
                if (clr_reg == BKT_BITS'(BKT_COUNT - 1)) state_next = ST_DONE;
            end
            ST_DONE:      if (!ov_reg || out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready = state_reg == ST_IDLE;
        hwe = 1'b0;
        hwaddr = bkt_reg;
        hwdata = used_reg + 1'b1;
        nwe = 1'b0;
        nwdata = {hrdata, val_reg, b_reg, a_reg};
        res_ld = 1'b0;
        res = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                hwe = 1'b1;
                hwaddr = clr_reg;
                hwdata = '0;
            end
            ST_CLEAR:
            begin
                hwe = 1'b1;
                hwaddr = clr_reg;
                hwdata = '0;
            end
            ST_DONE:
            begin
                res_ld = !ov_reg || out_ready;
                if (res_ld && act_reg == ACT_ENTER && used_reg != LB'(POOL_DEPTH))
                begin
                    hwe = 1'b1;
                    nwe = 1'b1;
                end
                res = {act_reg == ACT_ENTER && used_reg == LB'(POOL_DEPTH),
                       found_reg ? val_reg : 32'd0, found_reg};
            end
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            clr_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_ld)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (state_reg == ST_CLEAR)
            begin
                used_reg <= '0;
            end
            else if (nwe)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (load)
            begin
                clr_reg <= '0;
            end
            else if (state_reg == ST_INIT || state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (load)
            begin
                found_reg <= 1'b0;
            end
            else if (state_reg == ST_NODE_WAIT && link_reg != '0 && hit
                     && cnt_reg != LB'(POOL_DEPTH))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            {bkt_reg, val_reg, b_reg, a_reg, act_reg} <= q_data;
            cnt_reg <= '0;
        end
        if (state_reg == ST_HEAD_WAIT)
        begin
            link_reg <= hrdata;
        end
        if (state_reg == ST_IDLE)
        begin
            link_reg <= '0;
        end
        if (state_reg == ST_NODE_WAIT && link_reg != '0 && cnt_reg != LB'(POOL_DEPTH))
        begin
            if (hit)
            begin
                val_reg <= ne;
            end
            else
            begin
                link_reg <= nn;
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
        if (res_ld)
        begin
            od_reg <= res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= LB'(POOL_DEPTH))
        else $error("pool count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) nwe |-> hwe)
        else $error("node written without head update");
    assert property (@(posedge clk) disable iff (!rst_n) load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(od_reg))
        else $error("result changed while waiting");

endmodule

[hw/rtl/label_pair_hash_map.sv]
// top level of the label pair hash map
// a search step reads one node; a miss takes one extra step for the end of the chain
// the front accepts a new item only once the last is pushed into its queue; the back takes one at a time
// back memory: bucket heads and node pool in registered-read rams, each with one write and one read port
// reset: asynchronous active low, then a pass over every bucket empties the bucket heads
module label_pair_hash_map
    import lphm_pkg::*;
#(
    parameter int MOD_FIRST  = MOD_FIRST_DEF,
    parameter int MOD_SECOND = MOD_SECOND_DEF,
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int LABEL_BITS = LABEL_BITS_DEF,
    localparam int IN_BITS   = ((2 + 2 * LABEL_BITS + 32) + 7) / 8 * 8,
    localparam int BKT_BITS  = $clog2(MOD_FIRST + MOD_SECOND),
    localparam int QW        = 2 + 2 * LABEL_BITS + 32 + BKT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // action, label_first, label_second, entry_value
    input  logic [IN_BITS-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // found, entry_out, pool_full
    output logic [39:0]        m_axis_tdata
);

    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;
    logic [33:0]   od;

    lphm_front #(.MOD_FIRST(MOD_FIRST), .MOD_SECOND(MOD_SECOND),
                 .LABEL_BITS(LABEL_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_action(s_axis_tdata[1:0]),
        .in_a(s_axis_tdata[2 +: LABEL_BITS]),
        .in_b(s_axis_tdata[2 + LABEL_BITS +: LABEL_BITS]),
        .in_val(s_axis_tdata[2 + 2 * LABEL_BITS +: 32]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    lphm_back #(.MOD_FIRST(MOD_FIRST), .MOD_SECOND(MOD_SECOND),
                .POOL_DEPTH(POOL_DEPTH), .LABEL_BITS(LABEL_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
    );

    assign m_axis_tdata = {6'd0, od};

endmodule
